### rtl/core/lsc_pkg.sv
// shared constants, types and command/status bundles of the sprite compositor
package lsc_pkg;

   localparam int ROWS       = 64;
   localparam int COLS       = 64;
   localparam int NAME_BYTES = 8;
   localparam int CELLS      = ROWS * COLS;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int CUR_W      = ADDR_W;
   localparam int EXT_W      = 7;
   localparam int TOT_W      = 2 * EXT_W;
   localparam int POS_W      = 6;
   localparam int SUM_W      = POS_W + 1;
   localparam int CHAR_W     = 8;
   localparam int DEPTH_W    = 16;
   localparam int NAME_W     = 64;
   localparam int KIND_W     = 2;

   localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
      ((NAME_W'(1) << (8 * NAME_BYTES)) - NAME_W'(1));

   localparam logic [CHAR_W-1:0] TRANSPARENT = 8'h2E;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_EMIT  = 2'd2
   } lsc_kind_type;

   typedef struct packed {
      logic                      written;
      logic [CHAR_W-1:0]         glyph;
      logic signed [DEPTH_W-1:0] depth;
      logic [NAME_W-1:0]         name;
   } lsc_cell_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic clr_start;
      logic clr_step;
      logic pix_eval;
      logic pix_read;
      logic pix_write;
      logic em_mul;
      logic em_check;
      logic em_read;
      logic em_resp;
   } lsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic pix_drop;
      logic total_zero;
      logic div_done;
      logic rsp_free;
   } lsc_stat_type;

endpackage

### rtl/core/layered_sprite_compositor.sv
// layered sprite compositor top level: painter's-order color-key compositing
// pixel item: store read, compare and write; a dropped pixel skips the write
// emit item: multiply, check, 12-step divider, store read, then result; no result on an empty board
// clear item and reset: a clearing pass over the cell store, one cell a cycle
// reset is synchronous, active high; req_stall stays high through the clearing pass after it
// one item in flight; a stalled result holds back only the next emit, at its final step
module layered_sprite_compositor
   import lsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // item input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [DEPTH_W-1:0] req_layer_depth,
   input  logic [NAME_W-1:0]         req_name_key,
   input  logic [POS_W-1:0]          req_origin_row,
   input  logic [POS_W-1:0]          req_origin_col,
   input  logic [POS_W-1:0]          req_local_row,
   input  logic [POS_W-1:0]          req_local_col,
   input  logic [CHAR_W-1:0]         req_pixel_char,
   // board cell output channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_out_char,
   output logic                      rsp_row_end,
   output logic                      rsp_last,
   output logic [EXT_W-1:0]          rsp_board_height,
   output logic [EXT_W-1:0]          rsp_board_width,
   output logic                      rsp_overflow
);

   lsc_cmd_type  cmd;
   lsc_stat_type stat;

   // controller: owns the input handshake and walks each item through its steps
   lsc_ctrl u_lsc_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: cell store with written flag, extent, cursor, overflow and the
   // result register that decouples the output channel
   lsc_datapath u_lsc_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_layer_depth  (req_layer_depth),
      .req_name_key     (req_name_key),
      .req_origin_row   (req_origin_row),
      .req_origin_col   (req_origin_col),
      .req_local_row    (req_local_row),
      .req_local_col    (req_local_col),
      .req_pixel_char   (req_pixel_char),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_row_end      (rsp_row_end),
      .rsp_last         (rsp_last),
      .rsp_board_height (rsp_board_height),
      .rsp_board_width  (rsp_board_width),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

### rtl/core/lsc_div.sv
// radix-2 restoring divider: splits the emit cursor into row and column
module lsc_div
   import lsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CUR_W-1:0] dividend,
   input  logic [EXT_W-1:0] divisor,
   output logic [CUR_W-1:0] quotient,
   output logic [EXT_W-1:0] remainder,
   output logic             done
);

   localparam int CNT_W = $clog2(CUR_W + 1);

   logic [CUR_W-1:0] quo_ff, quo_in;
   logic [EXT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [EXT_W:0]   shifted;
   logic [EXT_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[CUR_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[CUR_W-2:0], ge};
         rem_in = ge ? diff[EXT_W-1:0] : shifted[EXT_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CUR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

### rtl/core/lsc_datapath.sv
// cell store, extent and cursor registers, depth compare and result register
module lsc_datapath
   import lsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lsc_cmd_type               cmd,
   output lsc_stat_type              stat,
   input  logic signed [DEPTH_W-1:0] req_layer_depth,
   input  logic [NAME_W-1:0]         req_name_key,
   input  logic [POS_W-1:0]          req_origin_row,
   input  logic [POS_W-1:0]          req_origin_col,
   input  logic [POS_W-1:0]          req_local_row,
   input  logic [POS_W-1:0]          req_local_col,
   input  logic [CHAR_W-1:0]         req_pixel_char,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [CHAR_W-1:0]         rsp_out_char,
   output logic                      rsp_row_end,
   output logic                      rsp_last,
   output logic [EXT_W-1:0]          rsp_board_height,
   output logic [EXT_W-1:0]          rsp_board_width,
   output logic                      rsp_overflow
);

   lsc_cell_type mem [CELLS];

   // latched item
   logic signed [DEPTH_W-1:0] depth_ff;
   logic [NAME_W-1:0]         key_ff;
   logic [SUM_W-1:0]          row_ff, col_ff;
   logic [CHAR_W-1:0]         glyph_ff;

   logic [EXT_W-1:0]  ext_rows_ff, ext_rows_in;
   logic [EXT_W-1:0]  ext_cols_ff, ext_cols_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [TOT_W-1:0]  total_ff;
   lsc_cell_type      rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_row_end_ff, rsp_last_ff, rsp_ovf_ff;
   logic [EXT_W-1:0]  rsp_height_ff, rsp_width_ff;

   logic              oob;
   logic [ADDR_W-1:0] pix_idx, em_idx;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   lsc_cell_type      mem_wd;
   logic              wins;
   logic              cur_past;
   logic              div_start;
   logic [CUR_W-1:0]  div_dividend;
   logic [CUR_W-1:0]  div_quo;
   logic [EXT_W-1:0]  div_rem;
   logic              div_done;
   logic              cell_last;

   lsc_div u_lsc_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (ext_cols_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      oob = (32'(row_ff) >= ROWS) || (32'(col_ff) >= COLS);
      pix_idx = ADDR_W'(32'(row_ff) * COLS + 32'(col_ff));
      em_idx  = ADDR_W'(32'(div_quo) * COLS + 32'(div_rem));

      wins = !rd_ff.written || (depth_ff < rd_ff.depth) ||
             ((depth_ff == rd_ff.depth) && (key_ff >= rd_ff.name));

      cur_past     = {{(TOT_W-CUR_W){1'b0}}, cursor_ff} >= total_ff;
      div_start    = cmd.em_check && (total_ff != '0);
      div_dividend = cur_past ? '0 : cursor_ff;
      cell_last    = ({{(TOT_W-CUR_W){1'b0}}, cursor_ff} + TOT_W'(1)) == total_ff;

      mem_we = 1'b0;
      mem_wa = pix_idx;
      mem_wd = '{written: 1'b1, glyph: glyph_ff, depth: depth_ff, name: key_ff};
      if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end else if (cmd.pix_write && wins) begin
         mem_we = 1'b1;
      end
      mem_re = cmd.pix_read || cmd.em_read;
      mem_ra = cmd.em_read ? em_idx : pix_idx;

      ext_rows_in = ext_rows_ff;
      ext_cols_in = ext_cols_ff;
      ovf_in      = ovf_ff;
      cursor_in   = cursor_ff;
      clr_addr_in = clr_addr_ff;

      if (cmd.clr_start) begin
         ext_rows_in = '0;
         ext_cols_in = '0;
         cursor_in   = '0;
         clr_addr_in = '0;
      end
      if (cmd.clr_step) begin
         clr_addr_in = (clr_addr_ff == ADDR_W'(CELLS - 1)) ? '0 : clr_addr_ff + ADDR_W'(1);
      end
      if (cmd.pix_eval) begin
         if (oob) begin
            ovf_in = 1'b1;
         end else begin
            if (EXT_W'(row_ff) + EXT_W'(1) > ext_rows_ff) ext_rows_in = EXT_W'(row_ff) + EXT_W'(1);
            if (EXT_W'(col_ff) + EXT_W'(1) > ext_cols_ff) ext_cols_in = EXT_W'(col_ff) + EXT_W'(1);
         end
      end
      if (cmd.em_check) begin
         if (total_ff == '0 || cur_past) cursor_in = '0;
      end
      if (cmd.em_resp) begin
         cursor_in = cell_last ? '0 : cursor_ff + CUR_W'(1);
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.em_resp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         depth_ff <= req_layer_depth;
         key_ff   <= req_name_key & NAME_MASK;
         row_ff   <= SUM_W'(req_origin_row) + SUM_W'(req_local_row);
         col_ff   <= SUM_W'(req_origin_col) + SUM_W'(req_local_col);
         glyph_ff <= req_pixel_char;
      end
      if (cmd.em_mul) begin
         total_ff <= TOT_W'(ext_rows_ff) * TOT_W'(ext_cols_ff);
      end
      if (cmd.em_resp) begin
         rsp_char_ff    <= rd_ff.written ? rd_ff.glyph : TRANSPARENT;
         rsp_row_end_ff <= ({1'b0, div_rem} + (EXT_W+1)'(1)) == {1'b0, ext_cols_ff};
         rsp_last_ff    <= cell_last;
         rsp_height_ff  <= ext_rows_ff;
         rsp_width_ff   <= ext_cols_ff;
         rsp_ovf_ff     <= ovf_ff;
      end
      if (reset) begin
         ext_rows_ff  <= '0;
         ext_cols_ff  <= '0;
         cursor_ff    <= '0;
         ovf_ff       <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ext_rows_ff  <= ext_rows_in;
         ext_cols_ff  <= ext_cols_in;
         cursor_ff    <= cursor_in;
         ovf_ff       <= ovf_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      stat.clr_last   = clr_addr_ff == ADDR_W'(CELLS - 1);
      stat.pix_drop   = oob || (glyph_ff == TRANSPARENT);
      stat.total_zero = total_ff == '0;
      stat.div_done   = div_done;
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_row_end      = rsp_row_end_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_board_height = rsp_height_ff;
   assign rsp_board_width  = rsp_width_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

### rtl/core/lsc_ctrl.sv
// sequencing state machine: clearing pass, pixel read-modify-write, emit steps
module lsc_ctrl
   import lsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_stall,
   output lsc_cmd_type       cmd,
   input  lsc_stat_type      stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_EM_MUL,
      ST_EM_CHK,
      ST_EM_DIV,
      ST_EM_RD,
      ST_EM_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (lsc_kind_type'(req_kind))
                  KIND_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  KIND_PIXEL: state_in = ST_PIX_RD;
                  KIND_EMIT:  state_in = ST_EM_MUL;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX_RD: begin
            cmd.pix_eval = 1'b1;
            cmd.pix_read = 1'b1;
            state_in     = stat.pix_drop ? ST_IDLE : ST_PIX_WR;
         end
         ST_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_EM_MUL: begin
            cmd.em_mul = 1'b1;
            state_in   = ST_EM_CHK;
         end
         ST_EM_CHK: begin
            cmd.em_check = 1'b1;
            state_in     = stat.total_zero ? ST_IDLE : ST_EM_DIV;
         end
         ST_EM_DIV: begin
            if (stat.div_done) state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            cmd.em_read = 1'b1;
            state_in    = ST_EM_RSP;
         end
         ST_EM_RSP: begin
            if (stat.rsp_free) begin
               cmd.em_resp = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= state_in != ST_IDLE;
      end
   end

   assign req_stall = stall_ff;

endmodule

### rtl/core/lsc_checker.sv
// port-level checks of the sprite compositor and their binding
module lsc_checker
   import lsc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [CHAR_W-1:0]         rsp_out_char,
   input logic                      rsp_row_end,
   input logic                      rsp_last,
   input logic [EXT_W-1:0]          rsp_board_height,
   input logic [EXT_W-1:0]          rsp_board_width,
   input logic                      rsp_overflow
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last)
         && $stable(rsp_row_end) && $stable(rsp_board_height) && $stable(rsp_board_width)
         && $stable(rsp_overflow))
      else $error("stalled result item changed");

   // last cell of the board also ends its row
   a_last_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_row_end)
      else $error("last cell without row end");

   // a cell only comes from a non-empty board within the store
   a_extent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_board_height != '0 && rsp_board_width != '0
         && 32'(rsp_board_height) <= ROWS && 32'(rsp_board_width) <= COLS)
      else $error("result item with bad board extent");

   // clearing pass follows reset
   a_reset_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("item accepted during clearing pass");

endmodule

bind layered_sprite_compositor lsc_checker u_lsc_checker (.*);
